// ----- rtl/cpta_pkg.sv -----
// Shared types and constants of the core pool team allocator.
package cpta_pkg;

  parameter int PROCS = 16;

  // Highest idle count and the widest scan the 16-bit masks allow.
  parameter int IDLE_LIMIT_INT = (PROCS - 1 > 15) ? 15 : PROCS - 1;
  parameter int SCAN_MAX_INT   = (PROCS > 16) ? 16 : PROCS;

  parameter logic [3:0] IDLE_LIMIT = 4'(IDLE_LIMIT_INT);
  parameter logic [4:0] SCAN_MAX   = 5'(SCAN_MAX_INT);
  parameter logic [4:0] PROCS_IN_USE_RESET = 5'd16;

  parameter int QUEUE_DEPTH = 2;
  parameter int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_END   = 1'b1
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [3:0]  requester;
    logic [4:0]  requested;
    logic [15:0] release_mask;
    logic [4:0]  release_count;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  member_core;
    logic [3:0]  member_local_id;
    logic [15:0] team_mask;
    logic [4:0]  granted;
    logic [3:0]  idle_after;
    logic        last;
  } result_t;

  // Classified request as it waits for the scan engine.
  typedef struct packed {
    op_e         op;
    logic [3:0]  req;
    logic [4:0]  grant;
    logic [3:0]  idle;
    logic [15:0] mask;
    logic [4:0]  scan_end;
  } entry_t;

endpackage

// ----- rtl/core_pool_team_allocator.sv -----
// Top level of the core pool team allocator: register port, front, queue, scan engine.
// With an idle engine, an end request passes through the queue and its result is
// registered by the scan engine; a start's scan tests at most cores 1 to min(procs_in_use, 16) - 1.
// Throughput: the scan engine tests one core per cycle and pops a new request only
// when idle; a two-entry queue absorbs requests, and results never stall.
// Reset clears the busy mask, sets the idle count to its limit and procs_in_use to 16.
module core_pool_team_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cpta_pkg::cmd_t    cmd_i,
  output logic              result_valid_o,
  output cpta_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [4:0]       procs_in_use_q;
  logic             accept;
  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  cpta_pkg::entry_t push_entry;
  cpta_pkg::entry_t head_entry;

  assign pready = 1'b1;
  assign accept = start && !busy;
  assign busy   = full;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, procs_in_use_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_in_use_q <= cpta_pkg::PROCS_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      procs_in_use_q <= pwdata[4:0];
    end
  end

  cpta_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .procs_in_use_i (procs_in_use_q),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  cpta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  cpta_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (head_entry),
    .empty_i        (empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // A start result always lists its own member, an end result lists the requester
  // only through the release mask, so this check covers the worker results of starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.member_local_id != 4'd0 |->
      result_o.team_mask[result_o.member_core])
    else $error("worker core missing from its team mask");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.member_local_id != 4'd0 |->
      {1'b0, result_o.member_local_id} < result_o.granted)
    else $error("more members emitted than granted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> result_o.member_local_id != 4'd15)
    else $error("sixteenth member not flagged as last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("scan engine took from an empty queue");

endmodule

// ----- rtl/cpta_front.sv -----
// Front end: takes requests, computes the grant and keeps the idle count.
module cpta_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cpta_pkg::cmd_t    cmd_i,
  input  logic [4:0]        procs_in_use_i,
  output logic              push_o,
  output cpta_pkg::entry_t  entry_o
);

  logic [3:0] idle_q, idle_d;
  logic [4:0] grant_full, grant, grant_m1, add;
  logic [5:0] sum;
  logic [3:0] idle_start, idle_end;
  logic [4:0] scan_end;

  always_comb begin
    grant_full = {1'b0, idle_q} + 5'd1;
    if (cmd_i.requested != 5'd0 && cmd_i.requested < grant_full) begin
      grant = cmd_i.requested;
    end else begin
      grant = grant_full;
    end
    grant_m1   = grant - 5'd1;
    idle_start = idle_q - grant_m1[3:0];

    add = (cmd_i.release_count != 5'd0) ? cmd_i.release_count - 5'd1 : 5'd0;
    sum = {2'b00, idle_q} + {1'b0, add};
    idle_end = (sum > {2'b00, cpta_pkg::IDLE_LIMIT}) ? cpta_pkg::IDLE_LIMIT : sum[3:0];

    scan_end = (procs_in_use_i > cpta_pkg::SCAN_MAX) ? cpta_pkg::SCAN_MAX
                                                     : procs_in_use_i;

    entry_o.op       = cmd_i.opcode;
    entry_o.req      = cmd_i.requester;
    entry_o.scan_end = scan_end;
    if (cmd_i.opcode == cpta_pkg::OP_END) begin
      entry_o.grant = cmd_i.release_count;
      entry_o.idle  = idle_end;
      entry_o.mask  = cmd_i.release_mask;
    end else begin
      entry_o.grant = grant;
      entry_o.idle  = idle_start;
      entry_o.mask  = 16'd0;
    end

    idle_d = accept_i ? entry_o.idle : idle_q;
  end

  assign push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= cpta_pkg::IDLE_LIMIT;
    end else begin
      idle_q <= idle_d;
    end
  end

endmodule

// ----- rtl/cpta_queue.sv -----
// Short queue of classified requests between front end and scan engine.
module cpta_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cpta_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output cpta_pkg::entry_t  entry_o,
  output logic              empty_o,
  output logic              full_o
);

  cpta_pkg::entry_t slots_q [cpta_pkg::QUEUE_DEPTH];
  logic [cpta_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [cpta_pkg::QUEUE_AW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (cpta_pkg::QUEUE_AW + 1)'(cpta_pkg::QUEUE_DEPTH));
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == (cpta_pkg::QUEUE_AW)'(cpta_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == (cpta_pkg::QUEUE_AW)'(cpta_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cpta_back.sv -----
// Scan engine: owns the busy mask, claims and releases cores and emits team members.
module cpta_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpta_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              result_valid_o,
  output cpta_pkg::result_t result_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e      state_q;
  logic [15:0] busy_q;
  logic [4:0]  idx_q;
  logic [4:0]  scan_end_q;
  logic [3:0]  left_q;
  logic [4:0]  grant_q;
  logic [3:0]  idle_q;
  logic [3:0]  pend_core_q;
  logic [3:0]  pend_lid_q;
  logic [15:0] mask_q;
  logic        res_valid_q;
  cpta_pkg::result_t res_q;

  logic        scan_done;
  logic        core_free;
  logic [15:0] core_bit;
  logic [4:0]  left_init;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign scan_done = (idx_q >= scan_end_q) || (left_q == 4'd0);
  assign core_free = !busy_q[idx_q[3:0]];
  assign core_bit  = 16'd1 << idx_q[3:0];
  assign left_init = entry_i.grant - 5'd1;

  // A member is held back one step so that the last one can be flagged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      idx_q       <= '0;
      scan_end_q  <= '0;
      left_q      <= '0;
      grant_q     <= '0;
      idle_q      <= '0;
      pend_core_q <= '0;
      pend_lid_q  <= '0;
      mask_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (entry_i.op == cpta_pkg::OP_END) begin
              busy_q <= busy_q & (~entry_i.mask | (16'd1 << entry_i.req));
              res_valid_q           <= 1'b1;
              res_q.member_core     <= entry_i.req;
              res_q.member_local_id <= 4'd0;
              res_q.team_mask       <= entry_i.mask;
              res_q.granted         <= entry_i.grant;
              res_q.idle_after      <= entry_i.idle;
              res_q.last            <= 1'b1;
            end else begin
              grant_q     <= entry_i.grant;
              idle_q      <= entry_i.idle;
              scan_end_q  <= entry_i.scan_end;
              left_q      <= left_init[3:0];
              idx_q       <= 5'd1;
              pend_core_q <= entry_i.req;
              pend_lid_q  <= 4'd0;
              mask_q      <= 16'd1 << entry_i.req;
              state_q     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            res_valid_q           <= 1'b1;
            res_q.member_core     <= pend_core_q;
            res_q.member_local_id <= pend_lid_q;
            res_q.team_mask       <= mask_q;
            res_q.granted         <= grant_q;
            res_q.idle_after      <= idle_q;
            res_q.last            <= 1'b1;
            state_q               <= ST_IDLE;
          end else begin
            if (core_free) begin
              res_valid_q           <= 1'b1;
              res_q.member_core     <= pend_core_q;
              res_q.member_local_id <= pend_lid_q;
              res_q.team_mask       <= mask_q;
              res_q.granted         <= grant_q;
              res_q.idle_after      <= idle_q;
              res_q.last            <= 1'b0;
              busy_q                <= busy_q | core_bit;
              mask_q                <= mask_q | core_bit;
              pend_core_q           <= idx_q[3:0];
              pend_lid_q            <= pend_lid_q + 4'd1;
              left_q                <= left_q - 4'd1;
            end
            idx_q <= idx_q + 5'd1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ----- sim/core_pool_team_allocator_test.sv -----
// Self-checking testbench for the core pool team allocator: directed and random team requests.
module core_pool_team_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 76;
  localparam int NUM_PHASES = 6;
  localparam logic [2:0] REG_PROCS_IN_USE = 3'd0;

  typedef struct packed {
    logic [3:0]  master;
    logic [15:0] mask;
    logic [4:0]  count;
  } team_t;

  // Tracks the core pool and the members each request is due to report.
  class allocation_ledger;
    cpta_pkg::result_t expected_members[$];
    logic [15:0]       busy_mask;
    logic [3:0]        idle_count;
    logic [4:0]        procs;
    int                failures;

    function new();
      busy_mask  = '0;
      idle_count = cpta_pkg::IDLE_LIMIT;
      procs      = cpta_pkg::PROCS_IN_USE_RESET;
      failures   = 0;
    endfunction

    // Applies one accepted request and queues its members; returns the final member.
    function cpta_pkg::result_t note_request(cpta_pkg::cmd_t c);
      cpta_pkg::result_t team[$];
      cpta_pkg::result_t r;
      logic [4:0]        grant;
      logic [4:0]        reach;
      logic [3:0]        left;
      logic [15:0]       members;
      int                sum;
      if (c.opcode == cpta_pkg::OP_END) begin
        busy_mask &= ~c.release_mask | (16'd1 << c.requester);
        sum = int'(idle_count) + ((c.release_count != 0) ? int'(c.release_count) - 1 : 0);
        idle_count = (sum > cpta_pkg::IDLE_LIMIT_INT) ? cpta_pkg::IDLE_LIMIT : 4'(sum);
        r.member_core     = c.requester;
        r.member_local_id = 4'd0;
        r.team_mask       = c.release_mask;
        r.granted         = c.release_count;
        r.idle_after      = idle_count;
        r.last            = 1'b1;
        team.push_back(r);
      end else begin
        grant = {1'b0, idle_count} + 5'd1;
        if (c.requested != 0 && c.requested < grant) begin
          grant = c.requested;
        end
        idle_count = idle_count - 4'(grant - 5'd1);
        reach = (procs > cpta_pkg::SCAN_MAX) ? cpta_pkg::SCAN_MAX : procs;
        members = 16'd1 << c.requester;
        left = 4'(grant - 5'd1);
        r.member_core     = c.requester;
        r.member_local_id = 4'd0;
        r.team_mask       = members;
        r.granted         = grant;
        r.idle_after      = idle_count;
        r.last            = 1'b0;
        team.push_back(r);
        // The master's own busy bit is not set, so a free master core can be claimed again.
        for (int i = 1; i < reach && left != 0; i++) begin
          if (!busy_mask[i]) begin
            busy_mask[i] = 1'b1;
            members[i] = 1'b1;
            left--;
            r.member_core     = 4'(i);
            r.member_local_id = 4'(team.size());
            r.team_mask       = members;
            team.push_back(r);
          end
        end
        r = team.pop_back();
        r.last = 1'b1;
        team.push_back(r);
      end
      foreach (team[k]) expected_members.push_back(team[k]);
      return team[team.size() - 1];
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_member(cpta_pkg::result_t got);
      cpta_pkg::result_t want;
      if (expected_members.size() == 0) begin
        $display("%0t: unexpected result, got core %0d id %0d mask %h", $time,
                 got.member_core, got.member_local_id, got.team_mask);
        failures++;
        return;
      end
      want = expected_members.pop_front();
      compare("member_core", want.member_core, got.member_core);
      compare("member_local_id", want.member_local_id, got.member_local_id);
      compare("team_mask", want.team_mask, got.team_mask);
      compare("granted", want.granted, got.granted);
      compare("idle_after", want.idle_after, got.idle_after);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  cpta_pkg::cmd_t    cmd     = '0;
  logic              result_valid;
  cpta_pkg::result_t result;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  allocation_ledger ledger;
  team_t            live_teams[$];
  int               stalled_cycles = 0;

  core_pool_team_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd),
    .result_valid_o(result_valid),
    .result_o      (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      ledger.check_member(result);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid || (psel && penable && pwrite && pready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL core_pool_team_allocator");
      $finish;
    end
  end

  // Holds the request until a transfer; start stays high for a following request.
  task automatic send_cmd(input cpta_pkg::cmd_t c);
    cpta_pkg::result_t tail;
    team_t             t;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
    tail = ledger.note_request(c);
    if (c.opcode == cpta_pkg::OP_START) begin
      t.master = c.requester;
      t.mask   = tail.team_mask;
      t.count  = tail.granted;
      live_teams.push_back(t);
    end
  endtask

  // Waits for every expected member, then waits on so the engine is surely idle.
  task automatic drain();
    start <= 1'b0;
    while (ledger.expected_members.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_procs(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PROCS_IN_USE;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.procs = value;
  endtask

  function automatic cpta_pkg::cmd_t make_cmd(cpta_pkg::op_e op, int req, int want, int rmask,
                                              int rcount);
    cpta_pkg::cmd_t c;
    c.opcode        = op;
    c.requester     = 4'(req);
    c.requested     = 5'(want);
    c.release_mask  = 16'(rmask);
    c.release_count = 5'(rcount);
    return c;
  endfunction

  // Mostly starts from free cores and ends of live teams, with some arbitrary requests.
  function automatic cpta_pkg::cmd_t next_random_cmd();
    cpta_pkg::cmd_t c;
    team_t          t;
    int             pick;
    int             k;
    c.opcode        = cpta_pkg::op_e'($urandom_range(0, 1));
    c.requester     = 4'($urandom_range(0, 15));
    c.requested     = 5'($urandom_range(0, 31));
    c.release_mask  = 16'($urandom_range(0, 65535));
    c.release_count = 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (live_teams.size() > 10 || (pick < 40 && live_teams.size() != 0)) begin
      k = $urandom_range(0, live_teams.size() - 1);
      t = live_teams[k];
      live_teams.delete(k);
      c.opcode        = cpta_pkg::OP_END;
      c.requester     = t.master;
      c.release_mask  = t.mask;
      c.release_count = t.count;
    end else if (pick < 88) begin
      c.opcode = cpta_pkg::OP_START;
      for (int tries = 0; tries < 4 && ledger.busy_mask[c.requester]; tries++) begin
        c.requester = 4'($urandom_range(0, 15));
      end
      c.requested = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 5));
    end
    return c;
  endfunction

  initial begin
    logic [4:0] phase_procs[NUM_PHASES];
    int         gap_pct[NUM_PHASES];
    ledger = new();
    phase_procs = '{5'd16, 5'd2, 5'd9, 5'd31, 5'($urandom_range(3, 15)), 5'd16};
    gap_pct     = '{25, 40, 0, 25, 40, 0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full grant, then requests while no core is idle.
    send_cmd(make_cmd(cpta_pkg::OP_START, 0, 0, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_START, 3, 5, 'hFFFF, 16));
    send_cmd(make_cmd(cpta_pkg::OP_START, 9, 16, 0, 0));
    send_cmd(make_cmd(cpta_pkg::OP_END, 0, 31, 'hFFFF, 16));
    send_cmd(make_cmd(cpta_pkg::OP_START, 5, 1, 0, 1));
    // The free master core 2 is claimed again as a worker.
    send_cmd(make_cmd(cpta_pkg::OP_START, 2, 3, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_START, 15, 31, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 1, 0, 'h0006, 2));
    send_cmd(make_cmd(cpta_pkg::OP_END, 15, 0, 0, 0));
    send_cmd(make_cmd(cpta_pkg::OP_END, 0, 0, 'hFFFF, 31));
    // Upper cores left busy while the idle count is full: the scan comes up short.
    send_cmd(make_cmd(cpta_pkg::OP_START, 0, 0, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 0, 0, 'h00FF, 16));
    send_cmd(make_cmd(cpta_pkg::OP_START, 0, 0, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 0, 0, 'hFFFF, 16));
    drain();
    write_procs(5'd0);
    send_cmd(make_cmd(cpta_pkg::OP_START, 4, 4, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 4, 0, 'h0010, 4));
    drain();
    write_procs(5'd1);
    send_cmd(make_cmd(cpta_pkg::OP_START, 0, 2, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 0, 0, 'h0001, 2));
    drain();
    write_procs(5'd2);
    send_cmd(make_cmd(cpta_pkg::OP_START, 0, 0, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 0, 0, 'h0003, 16));
    drain();
    write_procs(5'd31);
    send_cmd(make_cmd(cpta_pkg::OP_START, 7, 0, 0, 1));
    send_cmd(make_cmd(cpta_pkg::OP_END, 7, 0, 'hFFFF, 16));
    live_teams.delete();

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_procs(phase_procs[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) begin
          drain();
        end
        if (gap_pct[p] != 0 && $urandom_range(0, 99) < gap_pct[p]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
        send_cmd(next_random_cmd());
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (ledger.failures == 0) begin
      $display("PASS core_pool_team_allocator");
    end else begin
      $display("FAIL core_pool_team_allocator");
    end
    $finish;
  end

endmodule
